@@ rtl/ps2_mouse_packet_tracker_assert.svh @@
// Assertion macros shared by the mouse packet tracker modules.
// Included by the front, queue and back modules; no other dependencies.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/pmt_pkg.sv @@
// Shared types, constants and helpers for the mouse packet tracker.
// No dependencies; used by every module of the block.
package pmt_pkg;

	// Coordinate width default and configuration register layout.
	localparam int unsigned COORD_BITS_DEF = 12;
	localparam int unsigned SIZE_BITS      = 13;
	localparam int unsigned IDX_BITS       = 2;
	localparam int unsigned OUT_BITS       = 12;

	localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 13'd800;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 13'd600;
	localparam int unsigned X_RST = 400;
	localparam int unsigned Y_RST = 300;

	// Bits of the flags byte.
	localparam int unsigned SYNC_POS  = 3;
	localparam int unsigned LEFT_POS  = 0;
	localparam int unsigned RIGHT_POS = 1;

	// Command queue depth.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One decoded packet, handed from the front to the back.
	typedef struct packed {
		logic [7:0] dx;
		logic [7:0] dy;
		logic       left;
		logic       right;
	} cmd_t;

	// Largest coordinate for a screen size: size zero acts as one, size capped at 2^cb.
	function automatic logic [16:0] limit_of(logic [SIZE_BITS-1:0] size, int unsigned cb);
		logic [16:0] cap;
		logic [16:0] s;
		cap = 17'd1 << cb;
		s = 17'(size);
		if (s == 17'd0) begin
			s = 17'd1;
		end
		if (s > cap) begin
			s = cap;
		end
		return s - 17'd1;
	endfunction

endpackage

@@ rtl/pmt_front.sv @@
// Front end: accepts mouse bytes, tracks the byte position in the packet
// and pushes one command per packet with the sync bit set. Uses pmt_pkg.
`include "ps2_mouse_packet_tracker_assert.svh"

module pmt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	output logic             in_ready,
	input  logic             q_full,
	output logic             push,
	output pmt_pkg::cmd_t    push_cmd
);

	typedef enum logic [2:0] {
		ST_FLAGS = 3'b001,
		ST_DX    = 3'b010,
		ST_DY    = 3'b100
	} byte_state_t;

	byte_state_t state_q;
	logic [7:0]  flags_q;
	logic [7:0]  dx_q;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// A command leaves on the third beat when the sync bit of the flags byte is set.
	assign push = accept && (state_q == ST_DY) && flags_q[pmt_pkg::SYNC_POS];
	assign push_cmd.dx    = dx_q;
	assign push_cmd.dy    = in_byte;
	assign push_cmd.left  = flags_q[pmt_pkg::LEFT_POS];
	assign push_cmd.right = flags_q[pmt_pkg::RIGHT_POS];

	// Byte position within the packet; bad packets are not realigned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FLAGS;
		end else if (accept) begin
			case (state_q)
				ST_FLAGS: state_q <= ST_DX;
				ST_DX:    state_q <= ST_DY;
				ST_DY:    state_q <= ST_FLAGS;
				default:  state_q <= ST_FLAGS;
			endcase
		end
	end

	// Captured packet bytes.
	always_ff @(posedge clk) begin
		if (accept && state_q == ST_FLAGS) begin
			flags_q <= in_byte;
		end
		if (accept && state_q == ST_DX) begin
			dx_q <= in_byte;
		end
	end

	`PMT_ASSERT_NEXT(a_push_restarts, clk, arst_n, push, state_q == ST_FLAGS)
	`PMT_ASSERT_IMPLY(a_push_has_room, clk, arst_n, push, !q_full)

endmodule

@@ rtl/pmt_queue.sv @@
// Short command queue between the front and the back of the tracker.
// Uses pmt_pkg for the command type and its depth.
`include "ps2_mouse_packet_tracker_assert.svh"

module pmt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pmt_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output pmt_pkg::cmd_t head_cmd
);

	localparam int unsigned PTR_BITS = $clog2(pmt_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_BITS = $clog2(pmt_pkg::QUEUE_DEPTH + 1);

	pmt_pkg::cmd_t        slots_q [pmt_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 do_pop;

	assign full       = (count_q == CNT_BITS'(pmt_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slots_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(pmt_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(pmt_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	`PMT_ASSERT_IMPLY(a_no_overflow, clk, arst_n, 1'b1, count_q <= CNT_BITS'(pmt_pkg::QUEUE_DEPTH))

endmodule

@@ rtl/pmt_back.sv @@
// Back end: applies queued movement commands to the cursor, clamps it to
// the screen limits and holds the result beat. Uses pmt_pkg.
`include "ps2_mouse_packet_tracker_assert.svh"

module pmt_back #(
	parameter int unsigned COORD_BITS = pmt_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  pmt_pkg::cmd_t                 head_cmd,
	output logic                          pop,
	input  logic [COORD_BITS-1:0]         limit_x,
	input  logic [COORD_BITS-1:0]         limit_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pmt_pkg::OUT_BITS-1:0]  out_x,
	output logic [pmt_pkg::OUT_BITS-1:0]  out_y,
	output logic                          out_left,
	output logic                          out_right
);

	// Position registers also hold the reset position, which may exceed the limit.
	localparam int unsigned POS_W = (COORD_BITS > pmt_pkg::OUT_BITS) ? COORD_BITS
		: pmt_pkg::OUT_BITS;
	localparam int unsigned SUM_W = POS_W + 2;

	logic [POS_W-1:0]        pos_x_q;
	logic [POS_W-1:0]        pos_y_q;
	logic                    left_q;
	logic                    right_q;
	logic                    valid_q;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;
	logic [POS_W-1:0]        next_x;
	logic [POS_W-1:0]        next_y;

	assign pop = head_valid && (!valid_q || out_ready);

	// Add the deltas; Y is downward positive so its delta is subtracted.
	assign sum_x = $signed({2'b00, pos_x_q}) + SUM_W'($signed(head_cmd.dx));
	assign sum_y = $signed({2'b00, pos_y_q}) - SUM_W'($signed(head_cmd.dy));

	// Clamp to zero and the screen limit.
	always_comb begin
		if (sum_x[SUM_W-1]) begin
			next_x = '0;
		end else if (sum_x > $signed(SUM_W'(limit_x))) begin
			next_x = POS_W'(limit_x);
		end else begin
			next_x = sum_x[POS_W-1:0];
		end
		if (sum_y[SUM_W-1]) begin
			next_y = '0;
		end else if (sum_y > $signed(SUM_W'(limit_y))) begin
			next_y = POS_W'(limit_y);
		end else begin
			next_y = sum_y[POS_W-1:0];
		end
	end

	// Cursor position and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= POS_W'(pmt_pkg::X_RST);
			pos_y_q <= POS_W'(pmt_pkg::Y_RST);
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_x_q <= next_x;
				pos_y_q <= next_y;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Button state of the beat.
	always_ff @(posedge clk) begin
		if (pop) begin
			left_q  <= head_cmd.left;
			right_q <= head_cmd.right;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = pos_x_q[pmt_pkg::OUT_BITS-1:0];
	assign out_y     = pos_y_q[pmt_pkg::OUT_BITS-1:0];
	assign out_left  = left_q;
	assign out_right = right_q;

	`PMT_ASSERT_IMPLY(a_x_in_range, clk, arst_n, valid_q, pos_x_q <= POS_W'(limit_x))
	`PMT_ASSERT_IMPLY(a_y_in_range, clk, arst_n, valid_q, pos_y_q <= POS_W'(limit_y))

endmodule

@@ rtl/ps2_mouse_packet_tracker.sv @@
// Top level of the mouse packet tracker: configuration registers and the
// front, queue and back stages. Uses pmt_pkg and the pmt_* modules.
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------
//  s_axis  | in        | tdata[7:0] data_byte
//  m_axis  | out       | tdata cursor_x, cursor_y, left_button, right_button
//  cfg     | in        | cfg_index 0 screen_width, 1 screen_height
//
// One byte beat is taken per cycle while the queue is not full; a result beat
// passes the queue and then the back register after the third byte of a packet
// whose sync bit is set. The back stage updates the cursor once per command.
// Reset puts the cursor at (400, 300) and the screen at 800 by 600.
// A stalled output holds the back stage; the two-entry queue then fills and
// the input stalls once it is full.
module ps2_mouse_packet_tracker #(
	parameter int unsigned COORD_BITS = pmt_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [25] right_button
	output logic [31:0]                     m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [pmt_pkg::IDX_BITS-1:0]    cfg_index,
	input  logic [pmt_pkg::SIZE_BITS-1:0]   cfg_wdata
);

	localparam logic [16:0] LIM_X_RST = pmt_pkg::limit_of(pmt_pkg::WIDTH_RST, COORD_BITS);
	localparam logic [16:0] LIM_Y_RST = pmt_pkg::limit_of(pmt_pkg::HEIGHT_RST, COORD_BITS);

	logic [COORD_BITS-1:0]        limit_x_q;
	logic [COORD_BITS-1:0]        limit_y_q;
	logic [16:0]                  cfg_limit;
	logic                         q_full;
	logic                         push;
	pmt_pkg::cmd_t                push_cmd;
	logic                         pop;
	logic                         head_valid;
	pmt_pkg::cmd_t                head_cmd;
	logic [pmt_pkg::OUT_BITS-1:0] cur_x;
	logic [pmt_pkg::OUT_BITS-1:0] cur_y;
	logic                         btn_left;
	logic                         btn_right;

	// Screen sizes are kept as their clamp limits.
	assign cfg_limit = pmt_pkg::limit_of(cfg_wdata, COORD_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_x_q <= LIM_X_RST[COORD_BITS-1:0];
			limit_y_q <= LIM_Y_RST[COORD_BITS-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				pmt_pkg::REG_SCREEN_WIDTH:  limit_x_q <= cfg_limit[COORD_BITS-1:0];
				pmt_pkg::REG_SCREEN_HEIGHT: limit_y_q <= cfg_limit[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	pmt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_ready (s_axis_tready),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	pmt_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.limit_x    (limit_x_q),
		.limit_y    (limit_y_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_x      (cur_x),
		.out_y      (cur_y),
		.out_left   (btn_left),
		.out_right  (btn_right)
	);

	assign m_axis_tdata = {6'b000000, btn_right, btn_left, cur_y, cur_x};

endmodule
